FILE: hdl/dlle_pkg.sv
// Shared types and constants for the doubly linked list engine.
// No dependencies; imported by the controller, datapath and top modules.
package dlle_pkg;

   localparam int NODES  = 64;
   localparam int NODE_W = $clog2(NODES);
   localparam int LINK_W = $clog2(NODES + 1);
   localparam int CNT_W  = LINK_W;
   localparam int ACT_W  = 3;
   localparam logic [LINK_W-1:0] HEAD = LINK_W'(NODES);

   typedef enum logic [ACT_W-1:0] {
      ACT_LOOKUP       = 3'd0,
      ACT_ADD_FIRST    = 3'd1,
      ACT_ADD_LAST     = 3'd2,
      ACT_REMOVE_FIRST = 3'd3,
      ACT_INSERT_AFTER = 3'd4,
      ACT_REMOVE       = 3'd5,
      ACT_REMOVE_ALL   = 3'd6
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_START,
      ST_AF_RD_F, ST_AF_LINK, ST_AF_HEAD,
      ST_AL_LINK, ST_AL_HEAD,
      ST_RF_RD_F, ST_RF_LINK,
      ST_IA_LINK, ST_IA_FIX,
      ST_RM_LINK,
      ST_RA_FIRST, ST_RA_RD, ST_RA_SELF, ST_RA_HEAD,
      ST_RD_N, ST_RPT, ST_FIN
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD,
      OP_RD_HEAD, OP_RD_NODE, OP_RD_ANCHOR, OP_RD_LINK, OP_RD_TEMP,
      OP_AF_LINK, OP_AF_HEAD, OP_AL_LINK, OP_AL_HEAD,
      OP_RF_LINK, OP_IA_LINK, OP_IA_FIX, OP_RM_LINK,
      OP_RA_FIRST, OP_RA_SELF, OP_RA_HEAD,
      OP_RPT_NODE, OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             node_ok;
      logic             anchor_ok;
      logic             count_zero;
      logic             count_one;
      logic             out_busy;
   } status_type;

endpackage

FILE: hdl/dlle_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dlle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, hold when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: hdl/dlle_datapath.sv
// Link memories, valid bits, count and result registers of the list engine.
// Depends on dlle_pkg and dlle_ram.
module dlle_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  dlle_pkg::cmd_type                cmd,
   output dlle_pkg::status_type             status,
   input  logic [2:0]                       req_action,
   input  logic [5:0]                       req_node,
   input  logic [6:0]                       req_anchor_node,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [5:0]                       rsp_removed_node,
   output logic                             rsp_removed_valid,
   output logic [6:0]                       rsp_count,
   output logic [5:0]                       rsp_first_node,
   output logic                             rsp_first_valid,
   output logic [5:0]                       rsp_last_node,
   output logic                             rsp_last_valid,
   output logic [6:0]                       rsp_prev_node,
   output logic                             rsp_prev_valid,
   output logic [6:0]                       rsp_next_node,
   output logic                             rsp_next_valid
);
   import dlle_pkg::*;

   logic [ACT_W-1:0]  act_ff;
   logic [NODE_W-1:0] node_ff;
   logic [LINK_W-1:0] anchor_ff;
   logic [LINK_W-1:0] t1_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NODE_W-1:0] removed_ff;
   logic              removed_vld_ff;
   logic [LINK_W-1:0] pn_ff, nn_ff;
   logic              pv_ff, nv_ff;
   logic [LINK_W-1:0] rd_addr_ff;
   logic              nvq_ff, pvq_ff;
   logic [NODES:0]    next_vld_ff, prev_vld_ff;
   logic              rsp_valid_ff;

   logic [LINK_W-1:0] n_q, p_q, rn, rp, n_ext;
   logic              n_we, p_we, rd_en;
   logic [LINK_W-1:0] n_wa, n_wd, p_wa, p_wd, rd_a;
   logic              node_ok, count_zero;

   dlle_ram #(.WIDTH(LINK_W), .DEPTH(NODES + 1)) u_next_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_wa), .wr_data(n_wd),
      .rd_en(rd_en), .rd_addr(rd_a), .rd_data(n_q)
   );

   dlle_ram #(.WIDTH(LINK_W), .DEPTH(NODES + 1)) u_prev_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_en(rd_en), .rd_addr(rd_a), .rd_data(p_q)
   );

   // an entry never written reads as a link to itself
   assign rn      = nvq_ff ? n_q : rd_addr_ff;
   assign rp      = pvq_ff ? p_q : rd_addr_ff;
   assign n_ext   = LINK_W'(node_ff);
   assign node_ok = n_ext < HEAD;
   assign count_zero = (count_ff == '0);

   assign status.act        = act_ff;
   assign status.node_ok    = node_ok;
   assign status.anchor_ok  = (anchor_ff <= HEAD);
   assign status.count_zero = count_zero;
   assign status.count_one  = (count_ff == CNT_W'(1));
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   // decode the micro-operation into memory ports
   always_comb begin
      n_we = 1'b0; n_wa = '0; n_wd = '0;
      p_we = 1'b0; p_wa = '0; p_wd = '0;
      rd_en = 1'b0; rd_a = '0;
      case (cmd.op)
         OP_RD_HEAD:   begin rd_en = 1'b1; rd_a = HEAD; end
         OP_RD_NODE:   begin rd_en = 1'b1; rd_a = n_ext; end
         OP_RD_ANCHOR: begin rd_en = 1'b1; rd_a = anchor_ff; end
         OP_RD_LINK:   begin rd_en = 1'b1; rd_a = rn; end
         OP_RD_TEMP:   begin rd_en = 1'b1; rd_a = t1_ff; end
         OP_RPT_NODE:  begin rd_en = 1'b1; rd_a = HEAD; end
         OP_AF_LINK: begin
            p_we = 1'b1; p_wa = n_ext; p_wd = rp;
            n_we = 1'b1; n_wa = n_ext; n_wd = t1_ff;
         end
         OP_AF_HEAD: begin
            p_we = 1'b1; p_wa = t1_ff; p_wd = n_ext;
            n_we = 1'b1; n_wa = HEAD;  n_wd = n_ext;
         end
         OP_AL_LINK: begin
            n_we = 1'b1; n_wa = n_ext; n_wd = HEAD;
            p_we = 1'b1; p_wa = n_ext; p_wd = rp;
         end
         OP_AL_HEAD: begin
            n_we = 1'b1; n_wa = t1_ff; n_wd = n_ext;
            p_we = 1'b1; p_wa = HEAD;  p_wd = n_ext;
         end
         OP_RF_LINK: begin
            p_we = 1'b1; p_wa = rn;   p_wd = HEAD;
            n_we = 1'b1; n_wa = HEAD; n_wd = rn;
         end
         OP_IA_LINK: begin
            p_we = 1'b1; p_wa = n_ext; p_wd = anchor_ff;
            n_we = 1'b1; n_wa = n_ext; n_wd = rn;
         end
         OP_IA_FIX: begin
            p_we = 1'b1; p_wa = t1_ff;     p_wd = n_ext;
            n_we = 1'b1; n_wa = anchor_ff; n_wd = n_ext;
         end
         OP_RM_LINK: begin
            n_we = 1'b1; n_wa = rp; n_wd = rn;
            p_we = 1'b1; p_wa = rn; p_wd = rp;
         end
         OP_RA_SELF: begin
            n_we = 1'b1; n_wa = rd_addr_ff; n_wd = rd_addr_ff;
            p_we = 1'b1; p_wa = rd_addr_ff; p_wd = rd_addr_ff;
         end
         OP_RA_HEAD: begin
            n_we = 1'b1; n_wa = HEAD; n_wd = HEAD;
            p_we = 1'b1; p_wa = HEAD; p_wd = HEAD;
         end
         default: ;
      endcase
   end

   // saturating count update
   always_comb begin
      count_in = count_ff;
      case (cmd.op)
         OP_AF_HEAD, OP_AL_HEAD, OP_IA_FIX: begin
            if (count_ff < CNT_W'(NODES)) count_in = count_ff + CNT_W'(1);
         end
         OP_RF_LINK, OP_RM_LINK, OP_RA_SELF: begin
            if (!count_zero) count_in = count_ff - CNT_W'(1);
         end
         OP_RA_HEAD: count_in = '0;
         default: ;
      endcase
   end

   // control state: valid bits, count, result handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         next_vld_ff  <= '0;
         prev_vld_ff  <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (n_we) next_vld_ff[n_wa] <= 1'b1;
         if (p_we) prev_vld_ff[p_wa] <= 1'b1;
         count_ff <= count_in;
         if (cmd.op == OP_PUBLISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture transaction fields, temporaries and read tags
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         act_ff         <= req_action;
         node_ff        <= req_node;
         anchor_ff      <= req_anchor_node;
         removed_ff     <= '0;
         removed_vld_ff <= 1'b0;
      end
      if (rd_en) begin
         rd_addr_ff <= rd_a;
         nvq_ff     <= next_vld_ff[rd_a];
         pvq_ff     <= prev_vld_ff[rd_a];
      end
      case (cmd.op)
         OP_RD_LINK, OP_IA_LINK, OP_RA_FIRST, OP_RA_SELF: t1_ff <= rn;
         OP_AL_LINK: t1_ff <= rp;
         default: ;
      endcase
      if (cmd.op == OP_RF_LINK) begin
         removed_ff     <= t1_ff[NODE_W-1:0];
         removed_vld_ff <= 1'b1;
      end
      if (cmd.op == OP_RPT_NODE) begin
         pv_ff <= node_ok && (rp != n_ext);
         pn_ff <= (node_ok && (rp != n_ext)) ? rp : '0;
         nv_ff <= node_ok && (rn != n_ext);
         nn_ff <= (node_ok && (rn != n_ext)) ? rn : '0;
      end
   end

   // result register; first and last nodes are loaded from the head read
   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUBLISH) begin
         rsp_removed_node  <= removed_ff;
         rsp_removed_valid <= removed_vld_ff;
         rsp_count         <= count_ff;
         rsp_first_node    <= count_zero ? '0 : rn[NODE_W-1:0];
         rsp_first_valid   <= !count_zero;
         rsp_last_node     <= count_zero ? '0 : rp[NODE_W-1:0];
         rsp_last_valid    <= !count_zero;
         rsp_prev_node     <= pn_ff;
         rsp_prev_valid    <= pv_ff;
         rsp_next_node     <= nn_ff;
         rsp_next_valid    <= nv_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/dlle_controller.sv
// Sequencer of the list engine: walks each request through link read/write steps.
// Depends on dlle_pkg.
module dlle_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dlle_pkg::status_type  status,
   output dlle_pkg::cmd_type     cmd
);
   import dlle_pkg::*;

   state_type state_ff, state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // advance and issue commands
   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.op   = OP_RD_NODE;
            state_in = ST_RPT;
            case (status.act)
               ACT_ADD_FIRST: if (status.node_ok) begin
                  cmd.op = OP_RD_HEAD; state_in = ST_AF_RD_F;
               end
               ACT_ADD_LAST: if (status.node_ok) begin
                  cmd.op = OP_RD_HEAD; state_in = ST_AL_LINK;
               end
               ACT_REMOVE_FIRST: if (!status.count_zero) begin
                  cmd.op = OP_RD_HEAD; state_in = ST_RF_RD_F;
               end
               ACT_INSERT_AFTER: if (status.node_ok && status.anchor_ok) begin
                  cmd.op = OP_RD_ANCHOR; state_in = ST_IA_LINK;
               end
               ACT_REMOVE: if (status.node_ok) begin
                  cmd.op = OP_RD_NODE; state_in = ST_RM_LINK;
               end
               ACT_REMOVE_ALL: begin
                  cmd.op = OP_RD_HEAD; state_in = ST_RA_FIRST;
               end
               default: ;
            endcase
         end
         ST_AF_RD_F: begin cmd.op = OP_RD_LINK; state_in = ST_AF_LINK; end
         ST_AF_LINK: begin cmd.op = OP_AF_LINK; state_in = ST_AF_HEAD; end
         ST_AF_HEAD: begin cmd.op = OP_AF_HEAD; state_in = ST_RD_N; end
         ST_AL_LINK: begin cmd.op = OP_AL_LINK; state_in = ST_AL_HEAD; end
         ST_AL_HEAD: begin cmd.op = OP_AL_HEAD; state_in = ST_RD_N; end
         ST_RF_RD_F: begin cmd.op = OP_RD_LINK; state_in = ST_RF_LINK; end
         ST_RF_LINK: begin cmd.op = OP_RF_LINK; state_in = ST_RD_N; end
         ST_IA_LINK: begin cmd.op = OP_IA_LINK; state_in = ST_IA_FIX; end
         ST_IA_FIX:  begin cmd.op = OP_IA_FIX;  state_in = ST_RD_N; end
         ST_RM_LINK: begin cmd.op = OP_RM_LINK; state_in = ST_RD_N; end
         ST_RA_FIRST: begin
            cmd.op   = OP_RA_FIRST;
            state_in = status.count_zero ? ST_RA_HEAD : ST_RA_RD;
         end
         ST_RA_RD: begin cmd.op = OP_RD_TEMP; state_in = ST_RA_SELF; end
         ST_RA_SELF: begin
            cmd.op   = OP_RA_SELF;
            state_in = status.count_one ? ST_RA_HEAD : ST_RA_RD;
         end
         ST_RA_HEAD: begin cmd.op = OP_RA_HEAD; state_in = ST_RD_N; end
         ST_RD_N:    begin cmd.op = OP_RD_NODE; state_in = ST_RPT; end
         ST_RPT:     begin cmd.op = OP_RPT_NODE; state_in = ST_FIN; end
         ST_FIN: begin
            if (!status.out_busy) begin
               cmd.op   = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: hdl/doubly_linked_list_engine_top.sv
// Circular doubly linked list engine over 64 pool nodes plus a head sentinel
// (index 64). One transaction per request, one result transaction each. A
// request holds the engine from its acceptance until its result is published;
// lookups and refused requests go straight to the node read and report
// steps, while the other actions first run their link read and write steps.
// Remove all walks the list one member at a time. The step sequence is set
// by the single read port of each link memory, whose read data is registered.
// A finished result waits in an output register while the next request is
// accepted; a later result stalls in the final state until that register is
// free. Never-written links read as self-links, so no clearing pass follows
// reset. Depends on dlle_pkg, dlle_controller, dlle_datapath, dlle_ram.
module doubly_linked_list_engine_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_action,
   input  logic [5:0] req_node,
   input  logic [6:0] req_anchor_node,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_removed_node,
   output logic       rsp_removed_valid,
   output logic [6:0] rsp_count,
   output logic [5:0] rsp_first_node,
   output logic       rsp_first_valid,
   output logic [5:0] rsp_last_node,
   output logic       rsp_last_valid,
   output logic [6:0] rsp_prev_node,
   output logic       rsp_prev_valid,
   output logic [6:0] rsp_next_node,
   output logic       rsp_next_valid
);
   import dlle_pkg::*;

   cmd_type    cmd;
   status_type status;

   dlle_controller u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .status(status), .cmd(cmd)
   );

   dlle_datapath u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .status(status),
      .req_action(req_action), .req_node(req_node),
      .req_anchor_node(req_anchor_node),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_removed_node(rsp_removed_node), .rsp_removed_valid(rsp_removed_valid),
      .rsp_count(rsp_count),
      .rsp_first_node(rsp_first_node), .rsp_first_valid(rsp_first_valid),
      .rsp_last_node(rsp_last_node), .rsp_last_valid(rsp_last_valid),
      .rsp_prev_node(rsp_prev_node), .rsp_prev_valid(rsp_prev_valid),
      .rsp_next_node(rsp_next_node), .rsp_next_valid(rsp_next_valid)
   );

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CNT_W'(NODES)))
      else $error("count above pool size");

   a_removed_not_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_removed_valid) |-> (rsp_count < CNT_W'(NODES)))
      else $error("full count after a removal");

   a_first_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_first_valid == (rsp_count != '0)))
      else $error("first valid disagrees with count");

   a_neighbour_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_prev_valid) |-> (rsp_prev_node <= HEAD))
      else $error("previous link beyond sentinel");
`endif

endmodule
